// File: hw/rtl/ssc_pkg.sv
// Shared constants, types and codes of the state-space controller.
package ssc_pkg;

  localparam int MAX_ORDER  = 4;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int INDEX_W    = 5;
  localparam int ORDER_W    = 3;

  localparam int TABLE_SIZE = MAX_ORDER * MAX_ORDER + 2 * MAX_ORDER + 1;
  localparam int B_BASE     = MAX_ORDER * MAX_ORDER;
  localparam int C_BASE     = B_BASE + MAX_ORDER;
  localparam int D_SLOT     = C_BASE + MAX_ORDER;

  localparam int CA_W       = $clog2(TABLE_SIZE);
  localparam int IDX_W      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CNT_W      = $clog2(MAX_ORDER + 1);
  localparam int SA_W       = $clog2(2 * MAX_ORDER);
  localparam int ACC_W      = 2 * DATA_W + $clog2(MAX_ORDER + 1) + 1;

  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(2);

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_POST
  } seq_state_t;

  // One product issued into the multiply-accumulate pipeline.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             use_e;
    logic             copy;
    logic             to_drive;
    logic             done;
    logic [IDX_W-1:0] idx;
  } mac_op_t;

  // One finished, rounded and clipped sum.
  typedef struct packed {
    logic                     valid;
    logic                     to_drive;
    logic                     done;
    logic                     clipped;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
  } mac_res_t;

  typedef struct packed {
    logic                     we;
    logic [CA_W-1:0]          addr;
    logic signed [DATA_W-1:0] data;
  } coef_wr_t;

  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] data;
  } state_wr_t;

endpackage

// File: hw/rtl/ssc_in_if.sv
// Input channel: coefficient loads and control samples.
interface ssc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [ssc_pkg::INDEX_W-1:0]       coef_index;
  logic signed [ssc_pkg::DATA_W-1:0] coef_value;
  logic signed [ssc_pkg::DATA_W-1:0] setpoint;
  logic signed [ssc_pkg::DATA_W-1:0] measured;

  modport source (output valid, kind, coef_index, coef_value, setpoint, measured,
                  input ready);
  modport sink   (input valid, kind, coef_index, coef_value, setpoint, measured,
                  output ready);
endinterface

// File: hw/rtl/ssc_out_if.sv
// Result channel: controller drive and saturation flag.
interface ssc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ssc_pkg::DATA_W-1:0] drive;
  logic                              saturated;

  modport source (output valid, drive, saturated, input ready);
  modport sink   (input valid, drive, saturated, output ready);
endinterface

// File: hw/rtl/ssc_cfg_if.sv
// Configuration write channel for the state order register.
interface ssc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ssc_pkg::ORDER_W-1:0] state_order;

  modport source (output valid, state_order, input ready);
  modport sink   (input valid, state_order, output ready);
endinterface

// File: hw/rtl/ssc_coef_store.sv
// Coefficient memory: one write port, one registered read port.
module ssc_coef_store (
  input  logic                              clk,
  input  ssc_pkg::coef_wr_t                 wr,
  input  logic [ssc_pkg::CA_W-1:0]          raddr,
  output logic signed [ssc_pkg::DATA_W-1:0] rdata_r
);

  logic signed [ssc_pkg::DATA_W-1:0] mem [ssc_pkg::TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// File: hw/rtl/ssc_state_store.sv
// State vector memory, double banked: reads come from the current bank and
// the updated vector is written into the other one, which becomes current on flip.
module ssc_state_store (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [ssc_pkg::IDX_W-1:0]         ridx,
  output logic signed [ssc_pkg::DATA_W-1:0] rdata_r,
  input  ssc_pkg::state_wr_t                wr,
  input  logic                              flip
);

  logic signed [ssc_pkg::DATA_W-1:0] mem [2 * ssc_pkg::MAX_ORDER];
  logic [2*ssc_pkg::MAX_ORDER-1:0]   valid_r;
  logic                              bank_r;
  logic                              wbank;
  logic [ssc_pkg::SA_W-1:0]          raddr;
  logic [ssc_pkg::SA_W-1:0]          waddr;

  assign wbank = ~bank_r;
  assign raddr = ssc_pkg::SA_W'(bank_r) * ssc_pkg::SA_W'(ssc_pkg::MAX_ORDER)
               + ssc_pkg::SA_W'(ridx);
  assign waddr = ssc_pkg::SA_W'(wbank) * ssc_pkg::SA_W'(ssc_pkg::MAX_ORDER)
               + ssc_pkg::SA_W'(wr.idx);

  // Entries never written read as zero, which is the reset state vector.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      bank_r  <= 1'b0;
    end else begin
      if (wr.we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (flip) begin
        bank_r <= ~bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.data;
    end
    rdata_r <= valid_r[raddr] ? mem[raddr] : '0;
  end

endmodule

// File: hw/rtl/ssc_mac.sv
// Shared multiply-accumulate pipeline with round-to-nearest and 32-bit clipping.
module ssc_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ssc_pkg::mac_op_t                  op,
  input  logic signed [ssc_pkg::DATA_W-1:0] coef_q,
  input  logic signed [ssc_pkg::DATA_W-1:0] state_q,
  input  logic signed [ssc_pkg::DATA_W-1:0] err,
  output ssc_pkg::mac_res_t                 res_r
);

  localparam int AW = ssc_pkg::ACC_W;
  localparam int DW = ssc_pkg::DATA_W;
  localparam int FB = ssc_pkg::FRAC_BITS;
  localparam logic signed [AW-1:0] SAT_HI = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO = {{(AW-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic signed [AW-1:0] HALF   = {{(AW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

  ssc_pkg::mac_op_t        op1_r, op2_r, op3_r, op3_nxt;
  ssc_pkg::mac_res_t       res_nxt;
  logic signed [DW-1:0]    b_sel;
  logic signed [2*DW-1:0]  prod_w;
  logic signed [AW-1:0]    prod_nxt, prod_r;
  logic signed [AW-1:0]    acc_nxt, acc_r;
  logic signed [AW-1:0]    rnd_w;

  // Stage 1: memory data is present; form the product. A copy passes the old
  // state through scaled so that rounding returns it unchanged.
  always_comb begin
    b_sel  = op1_r.use_e ? err : state_q;
    prod_w = coef_q * b_sel;
    if (op1_r.copy) begin
      prod_nxt = AW'(state_q) <<< FB;
    end else begin
      prod_nxt = AW'(prod_w);
    end
  end

  // Stage 2: accumulate.
  always_comb begin
    acc_nxt       = (op2_r.first ? '0 : acc_r) + prod_r;
    op3_nxt       = op2_r;
    op3_nxt.valid = op2_r.valid && op2_r.last;
  end

  // Stage 3: round once and clip.
  always_comb begin
    rnd_w            = (acc_r + HALF) >>> FB;
    res_nxt.valid    = op3_r.valid;
    res_nxt.to_drive = op3_r.to_drive;
    res_nxt.done     = op3_r.done;
    res_nxt.idx      = op3_r.idx;
    res_nxt.clipped  = (rnd_w > SAT_HI) || (rnd_w < SAT_LO);
    if (rnd_w > SAT_HI) begin
      res_nxt.value = DW'(SAT_HI);
    end else if (rnd_w < SAT_LO) begin
      res_nxt.value = DW'(SAT_LO);
    end else begin
      res_nxt.value = DW'(rnd_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op1_r <= '0;
      op2_r <= '0;
      op3_r <= '0;
      res_r <= '0;
    end else begin
      op1_r <= op;
      op2_r <= op1_r;
      op3_r <= op3_nxt;
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (op2_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  a_res_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.valid |-> $past(op2_r.valid && op2_r.last, 2))
    else $error("result without a closing product two cycles earlier");

  a_first_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    op2_r.valid && $past(op2_r.valid && op2_r.last) |-> op2_r.first)
    else $error("sum continued past its closing product");

  a_copy_closes: assert property (@(posedge clk) disable iff (!rst_n)
    op1_r.valid && op1_r.copy |-> op1_r.first && op1_r.last)
    else $error("state copy is not a single-term sum");

endmodule

// File: hw/rtl/ssc_seq.sv
// Sequencer: takes transactions, walks the coefficient table and state vector
// through the shared multiply-accumulate, and holds the result register.
module ssc_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  ssc_in_if.sink                            in_ch,
  ssc_out_if.source                         out_ch,
  ssc_cfg_if.sink                           cfg_ch,
  output ssc_pkg::coef_wr_t                 coef_wr,
  output logic [ssc_pkg::CA_W-1:0]          coef_raddr,
  output logic [ssc_pkg::IDX_W-1:0]         state_ridx,
  output ssc_pkg::mac_op_t                  op,
  output logic signed [ssc_pkg::DATA_W-1:0] err,
  output logic                              bank_flip,
  input  ssc_pkg::mac_res_t                 res
);

  ssc_pkg::seq_state_t                state_r, state_nxt;
  logic [ssc_pkg::CNT_W-1:0]          grp_r, term_r;
  logic [ssc_pkg::ORDER_W-1:0]        order_r;
  logic signed [ssc_pkg::DATA_W-1:0]  err_r, drive_r, out_drive_r;
  logic                               sat_r, out_sat_r, out_valid_r;

  logic                               in_acc, sample_acc, slot_free;
  logic [ssc_pkg::CNT_W-1:0]          n_eff, row;
  logic [ssc_pkg::IDX_W-1:0]          row_idx, term_idx;
  logic                               is_copy, e_term;
  logic [ssc_pkg::DATA_W:0]           diff;
  logic                               e_ovf;
  logic signed [ssc_pkg::DATA_W-1:0]  e_clip;

  assign in_ch.ready  = (state_r == ssc_pkg::S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign sample_acc   = in_acc && (in_ch.kind == ssc_pkg::KIND_SAMPLE);
  assign slot_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.drive     = out_drive_r;
  assign out_ch.saturated = out_sat_r;

  assign err       = err_r;
  assign bank_flip = res.valid && res.done;

  assign coef_wr.we   = in_acc && (in_ch.kind == ssc_pkg::KIND_LOAD)
                     && (int'(in_ch.coef_index) < ssc_pkg::TABLE_SIZE);
  assign coef_wr.addr = ssc_pkg::CA_W'(in_ch.coef_index);
  assign coef_wr.data = in_ch.coef_value;

  // Error with saturation.
  always_comb begin
    diff   = {in_ch.setpoint[ssc_pkg::DATA_W-1], in_ch.setpoint}
           - {in_ch.measured[ssc_pkg::DATA_W-1], in_ch.measured};
    e_ovf  = diff[ssc_pkg::DATA_W] != diff[ssc_pkg::DATA_W-1];
    if (!e_ovf) begin
      e_clip = ssc_pkg::DATA_W'(diff);
    end else if (diff[ssc_pkg::DATA_W]) begin
      e_clip = {1'b1, {(ssc_pkg::DATA_W-1){1'b0}}};
    end else begin
      e_clip = {1'b0, {(ssc_pkg::DATA_W-1){1'b1}}};
    end
  end

  // Order zero acts as one, values above the maximum act as the maximum.
  always_comb begin
    if (order_r == '0) begin
      n_eff = ssc_pkg::CNT_W'(1);
    end else if (int'(order_r) > ssc_pkg::MAX_ORDER) begin
      n_eff = ssc_pkg::CNT_W'(ssc_pkg::MAX_ORDER);
    end else begin
      n_eff = ssc_pkg::CNT_W'(order_r);
    end
  end

  // Group zero forms the drive; group r+1 forms state row r, or copies the old
  // value forward when the row lies beyond the order.
  always_comb begin
    row      = grp_r - ssc_pkg::CNT_W'(1);
    row_idx  = ssc_pkg::IDX_W'(row);
    term_idx = ssc_pkg::IDX_W'(term_r);
    is_copy  = (grp_r != '0) && (row >= n_eff);
    e_term   = (term_r == n_eff);

    if (is_copy) begin
      coef_raddr = '0;
    end else if (grp_r == '0) begin
      coef_raddr = e_term ? ssc_pkg::CA_W'(ssc_pkg::D_SLOT)
                          : ssc_pkg::CA_W'(ssc_pkg::C_BASE) + ssc_pkg::CA_W'(term_r);
    end else if (e_term) begin
      coef_raddr = ssc_pkg::CA_W'(ssc_pkg::B_BASE) + ssc_pkg::CA_W'(row);
    end else begin
      coef_raddr = ssc_pkg::CA_W'(row) * ssc_pkg::CA_W'(ssc_pkg::MAX_ORDER)
                 + ssc_pkg::CA_W'(term_r);
    end

    if (is_copy) begin
      state_ridx = row_idx;
    end else if (e_term) begin
      state_ridx = '0;
    end else begin
      state_ridx = term_idx;
    end

    op.valid    = (state_r == ssc_pkg::S_RUN);
    op.first    = (term_r == '0);
    op.last     = is_copy || e_term;
    op.use_e    = e_term;
    op.copy     = is_copy;
    op.to_drive = (grp_r == '0);
    op.done     = (is_copy || e_term) && (grp_r == ssc_pkg::CNT_W'(ssc_pkg::MAX_ORDER));
    op.idx      = row_idx;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssc_pkg::S_IDLE: begin
        if (sample_acc) begin
          state_nxt = ssc_pkg::S_RUN;
        end
      end
      ssc_pkg::S_RUN: begin
        if (op.done) begin
          state_nxt = ssc_pkg::S_DRAIN;
        end
      end
      ssc_pkg::S_DRAIN: begin
        if (res.valid && res.done) begin
          state_nxt = ssc_pkg::S_POST;
        end
      end
      ssc_pkg::S_POST: begin
        if (slot_free) begin
          state_nxt = ssc_pkg::S_IDLE;
        end
      end
      default: state_nxt = ssc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r     <= ssc_pkg::ORDER_RESET;
      out_valid_r <= 1'b0;
      grp_r       <= '0;
      term_r      <= '0;
    end else begin
      if (cfg_ch.valid) begin
        order_r <= cfg_ch.state_order;
      end
      if (state_r == ssc_pkg::S_POST && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (sample_acc) begin
        grp_r  <= '0;
        term_r <= '0;
      end else if (state_r == ssc_pkg::S_RUN) begin
        if (op.last) begin
          grp_r  <= grp_r + ssc_pkg::CNT_W'(1);
          term_r <= '0;
        end else begin
          term_r <= term_r + ssc_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_acc) begin
      err_r <= e_clip;
      sat_r <= e_ovf;
    end else if (res.valid) begin
      sat_r <= sat_r | res.clipped;
    end
    if (res.valid && res.to_drive) begin
      drive_r <= res.value;
    end
    if (state_r == ssc_pkg::S_POST && slot_free) begin
      out_drive_r <= drive_r;
      out_sat_r   <= sat_r;
    end
  end

  a_res_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (state_r == ssc_pkg::S_RUN) || (state_r == ssc_pkg::S_DRAIN))
    else $error("sum finished while no sample is in progress");

  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.done |-> state_r == ssc_pkg::S_DRAIN)
    else $error("closing state row arrived outside the drain phase");

  a_out_from_post: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ssc_pkg::S_POST)
    else $error("result presented without a completed sample");

endmodule

// File: hw/rtl/state_space_controller.sv
// Top level of the discrete state-space controller.
//
//   channel   direction  transaction
//   in_ch     sink       load one coefficient (kind 0) or one control sample (kind 1)
//   out_ch    source     drive and saturated flag, one per control sample
//   cfg_ch    sink       state_order write, always ready
//
// A sample with order n issues (n+1) + n*(n+1) + (MAX_ORDER-n) products through
// the single multiply-accumulate, one product per cycle, followed by memory read,
// pipeline and result hand-off. The input is held off while a sample runs and
// while its result waits for a full output register. Reset clears the state
// vector at once through per-entry valid bits; the coefficient memory is not
// cleared and must be loaded before use.
module state_space_controller (
  input  logic      clk,
  input  logic      rst_n,
  ssc_in_if.sink    in_ch,
  ssc_out_if.source out_ch,
  ssc_cfg_if.sink   cfg_ch
);

  ssc_pkg::coef_wr_t                 coef_wr;
  ssc_pkg::state_wr_t                state_wr;
  ssc_pkg::mac_op_t                  op;
  ssc_pkg::mac_res_t                 res;
  logic [ssc_pkg::CA_W-1:0]          coef_raddr;
  logic [ssc_pkg::IDX_W-1:0]         state_ridx;
  logic signed [ssc_pkg::DATA_W-1:0] coef_q, state_q, err;
  logic                              bank_flip;

  assign state_wr.we   = res.valid && !res.to_drive;
  assign state_wr.idx  = res.idx;
  assign state_wr.data = res.value;

  ssc_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .coef_wr    (coef_wr),
    .coef_raddr (coef_raddr),
    .state_ridx (state_ridx),
    .op         (op),
    .err        (err),
    .bank_flip  (bank_flip),
    .res        (res)
  );

  ssc_coef_store u_coef (
    .clk     (clk),
    .wr      (coef_wr),
    .raddr   (coef_raddr),
    .rdata_r (coef_q)
  );

  ssc_state_store u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .ridx    (state_ridx),
    .rdata_r (state_q),
    .wr      (state_wr),
    .flip    (bank_flip)
  );

  ssc_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (op),
    .coef_q  (coef_q),
    .state_q (state_q),
    .err     (err),
    .res_r   (res)
  );

endmodule

// File: bench/tb_state_space_controller.sv
// Self-checking testbench of the state-space controller: loads, samples and order changes.
module tb_state_space_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import ssc_pkg::*;

  localparam int ACC_BITS = 72;
  localparam logic signed [ACC_BITS-1:0] ROUND_HALF = 72'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_BITS-1:0] S32_MAX = 72'sd2147483647;
  localparam logic signed [ACC_BITS-1:0] S32_MIN = -72'sd2147483648;
  // Orders of the random phases; 0 acts as 1 and 5..7 act as MAX_ORDER.
  localparam logic [23:0] ORDER_SEQ = {3'd6, 3'd5, 3'd2, 3'd7, 3'd0, 3'd3, 3'd1, 3'd4};
  localparam int PHASE_ITEMS = 50;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic                     kind;
    logic [INDEX_W-1:0]       coef_index;
    logic signed [DATA_W-1:0] coef_value;
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
  } ctrl_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     saturated;
  } drive_result_t;

  logic clk;
  logic rst_n;

  ssc_in_if  in_ch ();
  ssc_out_if out_ch ();
  ssc_cfg_if cfg_ch ();

  state_space_controller uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ctrl_item_t    pending_q[$];
  ctrl_item_t    next_item;
  drive_result_t drive_expect_q[$];
  drive_result_t want;
  drive_result_t got;

  // Predictor state: coefficient table, state vector and order register.
  logic signed [DATA_W-1:0]  model_coef [TABLE_SIZE];
  logic signed [DATA_W-1:0]  model_state [MAX_ORDER];
  logic        [ORDER_W-1:0] model_order;

  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left;
  bit hold_armed = 1'b0;
  bit hold_taken;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    in_ch.setpoint = '0;
    in_ch.measured = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.state_order = ORDER_RESET;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_BITS-1:0] v,
                                                     inout bit clip);
    if (v > S32_MAX) begin
      clip = 1'b1;
      return S32_MAX[DATA_W-1:0];
    end
    if (v < S32_MIN) begin
      clip = 1'b1;
      return S32_MIN[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

  // Output from the old state, then the state update, each sum rounded once.
  task automatic predict_sample(input logic signed [DATA_W-1:0] sp,
                                input logic signed [DATA_W-1:0] ms,
                                output drive_result_t res);
    logic signed [ACC_BITS-1:0] acc, fa, fb, ev;
    logic signed [DATA_W-1:0]   err;
    logic signed [DATA_W-1:0]   nxt [MAX_ORDER];
    int n;
    bit clip;
    clip = 1'b0;
    n = model_order;
    if (n < 1) n = 1;
    if (n > MAX_ORDER) n = MAX_ORDER;
    fa = sp;
    fb = ms;
    err = sat32(fa - fb, clip);
    ev = err;
    acc = '0;
    for (int c = 0; c < n; c++) begin
      fa = model_coef[C_BASE + c];
      fb = model_state[c];
      acc = acc + fa * fb;
    end
    fa = model_coef[D_SLOT];
    acc = acc + fa * ev;
    res.drive = sat32((acc + ROUND_HALF) >>> FRAC_BITS, clip);
    for (int r = 0; r < n; r++) begin
      acc = '0;
      for (int c = 0; c < n; c++) begin
        fa = model_coef[r * MAX_ORDER + c];
        fb = model_state[c];
        acc = acc + fa * fb;
      end
      fa = model_coef[B_BASE + r];
      acc = acc + fa * ev;
      nxt[r] = sat32((acc + ROUND_HALF) >>> FRAC_BITS, clip);
    end
    for (int r = 0; r < n; r++) model_state[r] = nxt[r];
    res.saturated = clip;
  endtask

  // Mostly small gains around zero, sometimes any pattern or a full-scale value.
  function automatic logic signed [DATA_W-1:0] rand_coef();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(32'd32768)) - 32'sd16384;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_signal();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(32'd2097152)) - 32'sd1048576;
    endcase
  endfunction

  task automatic queue_load(input int slot, input logic signed [DATA_W-1:0] value);
    ctrl_item_t it;
    it.kind = KIND_LOAD;
    it.coef_index = slot[INDEX_W-1:0];
    it.coef_value = value;
    it.setpoint = $urandom;
    it.measured = $urandom;
    pending_q.push_back(it);
  endtask

  task automatic queue_sample(input logic signed [DATA_W-1:0] sp,
                              input logic signed [DATA_W-1:0] ms);
    ctrl_item_t it;
    it.kind = KIND_SAMPLE;
    it.coef_index = $urandom;
    it.coef_value = $urandom;
    it.setpoint = sp;
    it.measured = ms;
    pending_q.push_back(it);
  endtask

  // A load leaves no result behind, so a margin follows the last result.
  task automatic wait_idle();
    while (pending_q.size() != 0 || in_ch.valid || drive_expect_q.size() != 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_order(input logic [ORDER_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.state_order <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Driver: offers the next pending transaction, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.kind <= next_item.kind;
        in_ch.coef_index <= next_item.coef_index;
        in_ch.coef_value <= next_item.coef_value;
        in_ch.setpoint <= next_item.setpoint;
        in_ch.measured <= next_item.measured;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure and one long hold-off when armed.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_taken) begin
      out_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: checks each result transaction, then predicts accepted inputs.
  always @(posedge clk) begin
    if (!rst_n) begin
      model_order = ORDER_RESET;
      foreach (model_state[i]) model_state[i] = '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (drive_expect_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result: expected none actual drive %0d saturated %0b",
                   $time, out_ch.drive, out_ch.saturated);
        end else begin
          want = drive_expect_q.pop_front();
          if (out_ch.drive !== want.drive) begin
            fail_count++;
            $display("%0t drive mismatch: expected %0d actual %0d",
                     $time, want.drive, out_ch.drive);
          end
          if (out_ch.saturated !== want.saturated) begin
            fail_count++;
            $display("%0t saturated mismatch: expected %0b actual %0b",
                     $time, want.saturated, out_ch.saturated);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) model_order = cfg_ch.state_order;
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == KIND_LOAD) begin
          if (in_ch.coef_index < TABLE_SIZE) model_coef[in_ch.coef_index] = in_ch.coef_value;
        end else begin
          predict_sample(in_ch.setpoint, in_ch.measured, got);
          drive_expect_q.push_back(got);
        end
      end
    end
  end

  initial begin
    int p;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 24;
    recv_idle_pct = 85;

    // Directed part at the reset order of two: only the slots it reads are loaded.
    queue_load(0, 32'sh0000_8000);
    queue_load(1, 32'shffff_c000);
    queue_load(4, 32'sh0001_0000);
    queue_load(5, 32'sh0000_0000);
    queue_load(B_BASE, 32'sh0000_4000);
    queue_load(B_BASE + 1, 32'sh7fff_ffff);
    queue_load(C_BASE, 32'sh8000_0000);
    queue_load(C_BASE + 1, 32'sh0000_2000);
    queue_load(D_SLOT, 32'sh0001_0000);
    queue_load(TABLE_SIZE, 32'sh1234_5678);
    queue_load(31, 32'shffff_ffff);
    queue_sample(32'sh0000_0000, 32'sh0000_0000);
    queue_sample(32'sh0001_8000, 32'sh0000_8000);
    queue_sample(32'sh7fff_ffff, 32'sh8000_0000);
    queue_sample(32'sh8000_0000, 32'sh7fff_ffff);
    queue_sample(32'sh8000_0000, 32'sh0000_0000);
    queue_load(D_SLOT, 32'sh8000_0000);
    queue_sample(32'sh0000_0001, 32'sh0000_0000);
    queue_sample(32'shffff_ffff, 32'sh0000_0000);
    queue_load(B_BASE + 1, 32'sh0000_0000);
    queue_load(C_BASE, 32'sh0000_8000);
    queue_sample(32'sh0000_8000, 32'sh0001_0000);
    queue_sample(32'sh7fff_ffff, 32'sh7fff_ffff);
    wait_idle();

    for (p = 0; p < 8; p++) begin
      write_order(ORDER_SEQ[p*3 +: 3]);
      if (p < 3) begin
        send_idle_pct = 24;
        recv_idle_pct = 85;
      end else if (p < 6) begin
        send_idle_pct = 85;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // The whole table is written before the first sample at a higher order.
      if (p == 0) for (int s = 0; s < TABLE_SIZE; s++) queue_load(s, rand_coef());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 70) queue_sample(rand_signal(), rand_signal());
        else if ($urandom_range(9) == 0) queue_load($urandom_range(31, TABLE_SIZE), $urandom);
        else queue_load($urandom_range(TABLE_SIZE - 1), rand_coef());
      end
      if (p == 6) hold_armed = 1'b1;
      wait_idle();
    end

    if (fail_count == 0 && drive_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_in_if.sv
hw/rtl/ssc_out_if.sv
hw/rtl/ssc_cfg_if.sv
hw/rtl/ssc_coef_store.sv
hw/rtl/ssc_state_store.sv
hw/rtl/ssc_mac.sv
hw/rtl/ssc_seq.sv
hw/rtl/state_space_controller.sv
bench/tb_state_space_controller.sv
